// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/dtdn_pkg.sv -----
// ----------------------------------------------------------------------------
// Date to day number package
// Widths, calendar constants, month tables and shared types.
// ----------------------------------------------------------------------------
package dtdn_pkg;

   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int COUNT_W   = 22;
   localparam int WIDE_W    = 23;   // unsaturated day count
   localparam int WDAY_W    = 3;
   localparam int LEAPS_W   = 12;
   localparam int BEFORE_W  = 9;
   localparam int Q4_W      = YEAR_W - 2;
   localparam int CENT_W    = 8;

   localparam int EPOCH_YEAR_INT = 1800;
   localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(EPOCH_YEAR_INT);

   // Leap days counted from year 1 up to the epoch year.
   localparam int LEAP_BASE_INT = (EPOCH_YEAR_INT - 1) / 4 - (EPOCH_YEAR_INT - 1) / 100
                                + (EPOCH_YEAR_INT - 1) / 400;

   localparam logic [WIDE_W-1:0] DAYS_PER_YEAR = WIDE_W'(365);

   // (y / 4) / 25 as a reciprocal multiply, exact for every 12-bit quotient
   localparam int DIV25_MUL   = 1311;
   localparam int DIV25_SHIFT = 15;
   localparam int DIV25_PROD_W = Q4_W + 11;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = DAY_W'(29);

   localparam logic [WDAY_W-1:0]  RESET_WEEKDAY = WDAY_W'(3);

   typedef struct packed {
      logic                leap;
      logic [LEAPS_W-1:0]  leap_days;   // leap days since 1 January of the epoch year
   } year_info_type;

   // Days in a month of a common year, zero for a code that is no month.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:                                       len = DAY_W'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

   // Days of a common year before the first of the month.
   function automatic logic [BEFORE_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [BEFORE_W-1:0] days;
      case (month)
         4'd2:    days = BEFORE_W'(31);
         4'd3:    days = BEFORE_W'(59);
         4'd4:    days = BEFORE_W'(90);
         4'd5:    days = BEFORE_W'(120);
         4'd6:    days = BEFORE_W'(151);
         4'd7:    days = BEFORE_W'(181);
         4'd8:    days = BEFORE_W'(212);
         4'd9:    days = BEFORE_W'(243);
         4'd10:   days = BEFORE_W'(273);
         4'd11:   days = BEFORE_W'(304);
         4'd12:   days = BEFORE_W'(334);
         default: days = '0;
      endcase
      return days;
   endfunction

   // Remainder by 7 of a small value (below 28).
   function automatic logic [WDAY_W-1:0] mod7_small(input logic [4:0] value);
      logic [4:0] rem;
      if (value >= 5'd21) begin
         rem = value - 5'd21;
      end else if (value >= 5'd14) begin
         rem = value - 5'd14;
      end else if (value >= 5'd7) begin
         rem = value - 5'd7;
      end else begin
         rem = value;
      end
      return rem[WDAY_W-1:0];
   endfunction

endpackage

// ----- hdl/dtdn_year_info.sv -----
// ----------------------------------------------------------------------------
// Year information
// Leap flag of a year and the leap days between the epoch and its January 1.
// ----------------------------------------------------------------------------
module dtdn_year_info (
   input  logic [dtdn_pkg::YEAR_W-1:0] year,
   output dtdn_pkg::year_info_type     info
);

   logic [dtdn_pkg::Q4_W-1:0]         q4;
   logic [dtdn_pkg::DIV25_PROD_W-1:0] prod;
   logic [dtdn_pkg::CENT_W-1:0]       cent;
   logic [dtdn_pkg::Q4_W-1:0]         rem25;
   logic                              div4;
   logic                              div100;
   logic                              div400;
   logic [dtdn_pkg::LEAPS_W:0]        leaps;

   assign q4   = year[dtdn_pkg::YEAR_W-1:2];
   // year / 100 = (year / 4) / 25
   assign prod = dtdn_pkg::DIV25_PROD_W'(q4) * dtdn_pkg::DIV25_PROD_W'(dtdn_pkg::DIV25_MUL);
   assign cent = prod[dtdn_pkg::DIV25_SHIFT +: dtdn_pkg::CENT_W];
   assign rem25 = q4 - dtdn_pkg::Q4_W'(dtdn_pkg::Q4_W'(cent) * dtdn_pkg::Q4_W'(25));

   assign div4   = (year[1:0] == 2'b00);
   assign div100 = div4 && (rem25 == '0);
   assign div400 = div100 && (cent[1:0] == 2'b00);

   // Counts for year-1 differ from those for year only when year is a multiple.
   always_comb begin
      leaps = (dtdn_pkg::LEAPS_W+1)'(q4) - (dtdn_pkg::LEAPS_W+1)'(div4)
            - (dtdn_pkg::LEAPS_W+1)'(cent) + (dtdn_pkg::LEAPS_W+1)'(div100)
            + (dtdn_pkg::LEAPS_W+1)'(cent[dtdn_pkg::CENT_W-1:2])
            - (dtdn_pkg::LEAPS_W+1)'(div400)
            - (dtdn_pkg::LEAPS_W+1)'(dtdn_pkg::LEAP_BASE_INT);
      info.leap      = (div4 && !div100) || div400;
      info.leap_days = leaps[dtdn_pkg::LEAPS_W-1:0];
   end

endmodule

// ----- hdl/date_to_day_number.sv -----
// ----------------------------------------------------------------------------
// Date to day number
// Checks a Gregorian date and returns its day number and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one date per beat; rsp_* returns one result per date, in
//   order. csr_wr_en/csr_wr_data set the weekday of 1 January 1800
//   (1=Monday .. 7=Sunday); write it only while no date is in flight.
//   A date before 1800, a month outside 1..12, a zero day or a day past the
//   month's end gives rsp_tuser=0 with zero data.
//   From the edge that accepts a request beat to rsp_tvalid a date passes
//   an input register, a stage for the year split (one 12x11
//   reciprocal multiply for the century) and the date checks, a stage for
//   the day count sum, and an output stage for saturation and the weekday.
//   Throughput is one date per cycle while rsp_tready stays high. When the
//   receiver stalls, the four stages fill up and req_tready drops once all
//   of them hold a beat; each stage advances as soon as the one after it
//   frees up. Reset empties the pipeline and sets the epoch weekday to Wednesday.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module date_to_day_number (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // day_of_month[4:0], month_number[8:5], year_number[22:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // day_count[21:0], weekday[24:22]
   output logic        rsp_tuser,    // date_valid
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data   // epoch_weekday
);

   logic [dtdn_pkg::WDAY_W-1:0]   epoch_wday_ff;

   logic                          s0_valid_ff;
   logic [dtdn_pkg::DAY_W-1:0]    s0_day_ff;
   logic [dtdn_pkg::MONTH_W-1:0]  s0_month_ff;
   logic [dtdn_pkg::YEAR_W-1:0]   s0_year_ff;

   logic                          s1_valid_ff;
   logic                          s1_ok_ff,     s1_ok_in;
   logic [dtdn_pkg::YEAR_W-1:0]   s1_years_ff,  s1_years_in;
   logic [dtdn_pkg::LEAPS_W-1:0]  s1_leaps_ff;
   logic [dtdn_pkg::BEFORE_W-1:0] s1_before_ff, s1_before_in;
   logic [dtdn_pkg::DAY_W-1:0]    s1_day_ff,    s1_day_in;

   logic                          s2_valid_ff;
   logic                          s2_ok_ff;
   logic [dtdn_pkg::WIDE_W-1:0]   s2_count_ff,  s2_count_in;

   logic                          s3_valid_ff;
   logic                          s3_ok_ff;
   logic [dtdn_pkg::COUNT_W-1:0]  s3_count_ff,  s3_count_in;
   logic [dtdn_pkg::WDAY_W-1:0]   s3_wday_ff,   s3_wday_in;

   logic                          adv0, adv1, adv2, adv3;
   dtdn_pkg::year_info_type       yinfo;
   logic [dtdn_pkg::DAY_W-1:0]    limit;
   logic [dtdn_pkg::WIDE_W:0]     count_octal;
   logic [5:0]                    digit_sum;
   logic [3:0]                    fold;

   // Advance a stage when it is empty or the next one moves on.
   assign adv3 = !s3_valid_ff || rsp_tready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign adv0 = !s0_valid_ff || adv1;
   assign req_tready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_wday_ff <= dtdn_pkg::RESET_WEEKDAY;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            epoch_wday_ff <= csr_wr_data;
         end
         if (adv0) begin
            s0_valid_ff <= req_tvalid;
         end
         if (adv1) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage 0: input register
   always_ff @(posedge clock) begin
      if (adv0) begin
         s0_day_ff   <= req_tdata[4:0];
         s0_month_ff <= req_tdata[8:5];
         s0_year_ff  <= req_tdata[22:9];
      end
   end

   // Stage 1: year split and date checks
   dtdn_year_info u_year_info (
      .year (s0_year_ff),
      .info (yinfo)
   );

   always_comb begin
      limit = dtdn_pkg::month_length(s0_month_ff);
      if (s0_month_ff == dtdn_pkg::MONTH_FEB && yinfo.leap) begin
         limit = dtdn_pkg::LEAP_FEB_DAYS;
      end
      s1_ok_in = (s0_year_ff >= dtdn_pkg::EPOCH_YEAR)
              && (s0_month_ff >= dtdn_pkg::MONTH_JAN) && (s0_month_ff <= dtdn_pkg::MONTH_DEC)
              && (s0_day_ff != '0) && (s0_day_ff <= limit);
      s1_years_in  = s0_year_ff - dtdn_pkg::EPOCH_YEAR;
      s1_before_in = dtdn_pkg::days_before_month(s0_month_ff)
                   + dtdn_pkg::BEFORE_W'(yinfo.leap && (s0_month_ff > dtdn_pkg::MONTH_FEB));
      s1_day_in    = s0_day_ff - dtdn_pkg::DAY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ok_ff     <= s1_ok_in;
         s1_years_ff  <= s1_years_in;
         s1_leaps_ff  <= yinfo.leap_days;
         s1_before_ff <= s1_before_in;
         s1_day_ff    <= s1_day_in;
      end
   end

   // Stage 2: day count
   assign s2_count_in = dtdn_pkg::WIDE_W'(s1_years_ff) * dtdn_pkg::DAYS_PER_YEAR
                      + dtdn_pkg::WIDE_W'(s1_leaps_ff)
                      + dtdn_pkg::WIDE_W'(s1_before_ff)
                      + dtdn_pkg::WIDE_W'(s1_day_ff);

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_ok_ff    <= s1_ok_ff;
         s2_count_ff <= s2_count_in;
      end
   end

   // Stage 3: saturate and find the weekday; 8 == 1 mod 7, so sum octal digits
   always_comb begin
      count_octal = {1'b0, s2_count_ff};
      digit_sum = '0;
      for (int i = 0; i < 8; i++) begin
         digit_sum = digit_sum + 6'(count_octal[3*i +: 3]);
      end
      fold = 4'(digit_sum[2:0]) + 4'(digit_sum[5:3]);
      s3_wday_in = dtdn_pkg::mod7_small(5'(fold) + 5'(epoch_wday_ff) + 5'd6)
                 + dtdn_pkg::WDAY_W'(1);
      if (s2_count_ff[dtdn_pkg::WIDE_W-1]) begin
         s3_count_in = '1;
      end else begin
         s3_count_in = s2_count_ff[dtdn_pkg::COUNT_W-1:0];
      end
      if (!s2_ok_ff) begin
         s3_count_in = '0;
         s3_wday_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_ok_ff    <= s2_ok_ff;
         s3_count_ff <= s3_count_in;
         s3_wday_ff  <= s3_wday_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tuser  = s3_ok_ff;
   assign rsp_tdata  = {7'd0, s3_wday_ff, s3_count_ff};

   `ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPLY(a_valid_weekday, clock, reset, rsp_tvalid && rsp_tuser,
                 rsp_tdata[24:22] != 3'd0)
   `ASSERT_NEXT(a_stage1_hold, clock, reset, s1_valid_ff && !adv2,
                s1_valid_ff && $stable(s1_years_ff) && $stable(s1_ok_ff))
   `ASSERT_IMPLY(a_ready_when_drained, clock, reset, rsp_tready, req_tready)

endmodule
